### hw/rtl/coap_pkg.sv
// Shared types and constants for the CoAP message parser.
// Holds the parse phase enum, byte class and status codes, and the result record.
// No dependencies.
`default_nettype none

package coap_pkg;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'd0,
    PH_TOKEN   = 4'd1,
    PH_OPTHEAD = 4'd2,
    PH_D1      = 4'd3,
    PH_D2HI    = 4'd4,
    PH_D2LO    = 4'd5,
    PH_L1      = 4'd6,
    PH_L2HI    = 4'd7,
    PH_L2LO    = 4'd8,
    PH_VALUE   = 4'd9,
    PH_PAYLOAD = 4'd10,
    PH_SKIP    = 4'd11
  } phase_t;

  typedef logic [2:0] kind_t;
  localparam kind_t K_HEADER  = 3'd0;
  localparam kind_t K_TOKEN   = 3'd1;
  localparam kind_t K_OPTHEAD = 3'd2;
  localparam kind_t K_OPTEXT  = 3'd3;
  localparam kind_t K_VALUE   = 3'd4;
  localparam kind_t K_MARKER  = 3'd5;
  localparam kind_t K_PAYLOAD = 3'd6;
  localparam kind_t K_IGNORED = 3'd7;

  typedef logic [2:0] status_t;
  localparam status_t ST_BUSY    = 3'd0;
  localparam status_t ST_OK      = 3'd1;
  localparam status_t ST_SHORT   = 3'd2;
  localparam status_t ST_VERSION = 3'd3;
  localparam status_t ST_TOKEN   = 3'd4;
  localparam status_t ST_BADOPT  = 3'd5;
  localparam status_t ST_TRUNC   = 3'd6;

  localparam logic [7:0]  PAYLOAD_MARK = 8'hFF;
  localparam logic [3:0]  NIB_EXT8     = 4'd13;
  localparam logic [3:0]  NIB_EXT16    = 4'd14;
  localparam logic [3:0]  NIB_RSVD     = 4'd15;
  localparam logic [1:0]  COAP_VER     = 2'b01;
  localparam logic [3:0]  TKL_MAX      = 4'd8;
  localparam logic [16:0] EXT8_BIAS    = 17'd13;
  localparam logic [16:0] EXT16_BIAS   = 17'd269;

  typedef struct packed {
    kind_t        byte_kind;
    logic [7:0]   data_byte;
    logic [1:0]   msg_type;
    logic [3:0]   token_len;
    logic [7:0]   msg_code;
    logic [15:0]  msg_id;
    logic [15:0]  opt_number;
    logic [15:0]  opt_length;
    logic [4:0]   opt_count;
    logic         is_final;
    status_t      status;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/coap_if.sv
// Valid/ready channel interfaces for the CoAP message parser.
// coap_in_if carries datagram bytes, coap_out_if carries classified results.
// No dependencies.
`default_nettype none

interface coap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface coap_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  byte_kind;
  logic [7:0]  data_byte;
  logic [1:0]  msg_type;
  logic [3:0]  token_len;
  logic [7:0]  msg_code;
  logic [15:0] msg_id;
  logic [15:0] opt_number;
  logic [15:0] opt_length;
  logic [4:0]  opt_count;
  logic        is_final;
  logic [2:0]  status;

  modport source (output valid, output byte_kind, output data_byte, output msg_type,
                  output token_len, output msg_code, output msg_id, output opt_number,
                  output opt_length, output opt_count, output is_final, output status,
                  input ready);
  modport sink   (input valid, input byte_kind, input data_byte, input msg_type,
                  input token_len, input msg_code, input msg_id, input opt_number,
                  input opt_length, input opt_count, input is_final, input status,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/coap_message_parser.sv
// CoAP message parser: classifies one datagram byte per transaction.
// Each accepted byte's result is registered in the result queue and offered on tx in order.
// Throughput: one byte per cycle unless the result queue is full; parse state updates in one pass per byte.
// A two-entry result queue keeps rx open while one result waits on tx.
// Reset (rst, synchronous) returns to header phase, clears held fields, empties queue.
// Depends on coap_pkg and coap_if.
`default_nettype none

module coap_message_parser
  import coap_pkg::*;
#(
  parameter int MAX_DATAGRAM = 1024,
  parameter int MAX_OPTIONS  = 16
) (
  input  wire          clk,
  input  wire          rst,
  coap_in_if.sink      rx,
  coap_out_if.source   tx
);

  localparam int POS_W = $clog2(MAX_DATAGRAM + 1);
  localparam int CNT_W = $clog2(MAX_OPTIONS + 1);

  // parse state
  phase_t             phase, phase_next;
  logic [POS_W-1:0]   pos, pos_next;
  logic [1:0]         held_type, held_type_next;
  logic [3:0]         held_tkl, held_tkl_next;
  logic [7:0]         held_code, held_code_next;
  logic [15:0]        held_id, held_id_next;
  logic [15:0]        run_opt, run_opt_next;
  logic [7:0]         ext_hi, ext_hi_next;
  logic [15:0]        left, left_next;
  logic [3:0]         pend_len, pend_len_next;
  logic [CNT_W-1:0]   opt_cnt, opt_cnt_next;
  status_t            err, err_next;
  logic [15:0]        opt_len, opt_len_next;

  logic               accept;
  logic [7:0]         b;
  logic               fin;
  logic               in_range;
  logic               active;
  logic               opts_full;

  logic [16:0]        ext16_val;
  logic [16:0]        ext8_val;
  logic [16:0]        delta_val;
  logic [17:0]        delta_sum;
  logic [16:0]        len_val;
  logic [3:0]         len_nib;
  logic               do_delta;
  logic               do_len;

  kind_t              kind;
  status_t            status;
  result_t            res;
  logic [6:0]         cnt_wide;

  assign b         = rx.in_byte;
  assign fin       = rx.last_byte;
  assign accept    = rx.valid && rx.ready;
  assign in_range  = (pos < POS_W'(MAX_DATAGRAM));
  assign active    = in_range && (err == ST_BUSY);
  assign opts_full = (opt_cnt >= CNT_W'(MAX_OPTIONS));

  assign ext8_val  = {9'd0, b} + EXT8_BIAS;
  assign ext16_val = {1'b0, ext_hi, b} + EXT16_BIAS;
  assign len_nib   = (phase == PH_OPTHEAD) ? b[3:0] : pend_len;

  always_comb begin
    case (phase)
      PH_D1:   delta_val = ext8_val;
      PH_D2LO: delta_val = ext16_val;
      default: delta_val = {13'd0, b[7:4]};
    endcase
  end
  assign delta_sum = {2'b00, run_opt} + {1'b0, delta_val};

  // next-state logic
  always_comb begin
    phase_next    = phase;
    pos_next      = pos;
    held_type_next = held_type;
    held_tkl_next = held_tkl;
    held_code_next = held_code;
    held_id_next  = held_id;
    run_opt_next  = run_opt;
    ext_hi_next   = ext_hi;
    left_next     = left;
    pend_len_next = pend_len;
    opt_cnt_next  = opt_cnt;
    err_next      = err;
    opt_len_next  = opt_len;
    do_delta      = 1'b0;
    do_len        = 1'b0;
    len_val       = {13'd0, len_nib};

    if (in_range) begin
      pos_next = pos + POS_W'(1);
    end
    if (active) begin
      case (phase)
        PH_HEADER: begin
          case (pos[1:0])
            2'd0: begin
              held_type_next = b[5:4];
              held_tkl_next  = b[3:0];
              if (b[7:6] != COAP_VER) begin
                err_next = ST_VERSION;
              end else if (b[3:0] > TKL_MAX) begin
                err_next = ST_TOKEN;
              end
            end
            2'd1: held_code_next = b;
            2'd2: held_id_next = {b, 8'd0};
            default: begin
              held_id_next = {held_id[15:8], b};
              left_next    = {12'd0, held_tkl};
              phase_next   = (held_tkl != 4'd0) ? PH_TOKEN : PH_OPTHEAD;
            end
          endcase
        end
        PH_TOKEN, PH_VALUE: begin
          if (left != 16'd0) begin
            left_next = left - 16'd1;
          end
          if (left_next == 16'd0) begin
            phase_next = PH_OPTHEAD;
          end
        end
        PH_OPTHEAD: begin
          if (b == PAYLOAD_MARK) begin
            phase_next = PH_PAYLOAD;
          end else if (opts_full) begin
            phase_next = PH_SKIP;
          end else begin
            pend_len_next = b[3:0];
            if (b[7:4] == NIB_RSVD || b[3:0] == NIB_RSVD) begin
              err_next = ST_BADOPT;
            end else if (b[7:4] == NIB_EXT8) begin
              phase_next = PH_D1;
            end else if (b[7:4] == NIB_EXT16) begin
              phase_next = PH_D2HI;
            end else begin
              do_delta = 1'b1;
            end
          end
        end
        PH_D1, PH_D2LO: do_delta = 1'b1;
        PH_D2HI, PH_L2HI: begin
          ext_hi_next = b;
          phase_next  = (phase == PH_D2HI) ? PH_D2LO : PH_L2LO;
        end
        PH_L1: begin
          do_len  = 1'b1;
          len_val = ext8_val;
        end
        PH_L2LO: begin
          do_len  = 1'b1;
          len_val = ext16_val;
        end
        default: begin
        end
      endcase

      if (do_delta) begin
        if (delta_sum[17:16] != 2'b00) begin
          err_next = ST_BADOPT;
        end else begin
          run_opt_next = delta_sum[15:0];
          if (len_nib == NIB_EXT8) begin
            phase_next = PH_L1;
          end else if (len_nib == NIB_EXT16) begin
            phase_next = PH_L2HI;
          end else begin
            do_len = 1'b1;
          end
        end
      end

      if (do_len) begin
        if (len_val[16]) begin
          err_next = ST_BADOPT;
        end else begin
          opt_len_next = len_val[15:0];
          left_next    = len_val[15:0];
          opt_cnt_next = opt_cnt + CNT_W'(1);
          phase_next   = (len_val != 17'd0) ? PH_VALUE : PH_OPTHEAD;
        end
      end
    end
  end

  // byte class and end-of-message status
  always_comb begin
    kind = K_IGNORED;
    if (active) begin
      case (phase)
        PH_HEADER:  kind = K_HEADER;
        PH_TOKEN:   kind = K_TOKEN;
        PH_OPTHEAD: begin
          if (b == PAYLOAD_MARK) begin
            kind = K_MARKER;
          end else if (opts_full) begin
            kind = K_IGNORED;
          end else begin
            kind = K_OPTHEAD;
          end
        end
        PH_D1, PH_D2HI, PH_D2LO, PH_L1, PH_L2HI, PH_L2LO: kind = K_OPTEXT;
        PH_VALUE:   kind = K_VALUE;
        PH_PAYLOAD: kind = K_PAYLOAD;
        default:    kind = K_IGNORED;
      endcase
    end

    status = ST_BUSY;
    if (fin) begin
      if (pos_next < POS_W'(4)) begin
        status = ST_SHORT;
      end else if (err_next != ST_BUSY) begin
        status = err_next;
      end else if (phase_next inside {[PH_D1:PH_VALUE]}) begin
        status = ST_TRUNC;
      end else begin
        status = ST_OK;
      end
    end
  end

  assign cnt_wide = 7'(opt_cnt_next);

  always_comb begin
    res.byte_kind  = kind;
    res.data_byte  = b;
    res.msg_type   = held_type_next;
    res.token_len  = held_tkl_next;
    res.msg_code   = held_code_next;
    res.msg_id     = held_id_next;
    res.opt_number = run_opt_next;
    res.opt_length = opt_len_next;
    res.opt_count  = (cnt_wide > 7'd31) ? 5'd31 : cnt_wide[4:0];
    res.is_final   = fin;
    res.status     = status;
  end

  // clear per-message state on reset or after the final byte, else update it per accepted byte
  always_ff @(posedge clk) begin
    if (rst || (accept && fin)) begin
      phase     <= PH_HEADER;
      pos       <= '0;
      held_type <= '0;
      held_tkl  <= '0;
      held_code <= '0;
      held_id   <= '0;
      run_opt   <= '0;
      ext_hi    <= '0;
      left      <= '0;
      pend_len  <= '0;
      opt_cnt   <= '0;
      err       <= ST_BUSY;
      opt_len   <= '0;
    end else if (accept) begin
      phase     <= phase_next;
      pos       <= pos_next;
      held_type <= held_type_next;
      held_tkl  <= held_tkl_next;
      held_code <= held_code_next;
      held_id   <= held_id_next;
      run_opt   <= run_opt_next;
      ext_hi    <= ext_hi_next;
      left      <= left_next;
      pend_len  <= pend_len_next;
      opt_cnt   <= opt_cnt_next;
      err       <= err_next;
      opt_len   <= opt_len_next;
    end
  end

  // two-entry result queue
  result_t    q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       pop;
  result_t    head;

  assign rx.ready = (fill != 2'd2);
  assign pop      = tx.valid && tx.ready;
  assign tx.valid = (fill != 2'd0);
  assign head     = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (accept) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({accept, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

  assign tx.byte_kind  = head.byte_kind;
  assign tx.data_byte  = head.data_byte;
  assign tx.msg_type   = head.msg_type;
  assign tx.token_len  = head.token_len;
  assign tx.msg_code   = head.msg_code;
  assign tx.msg_id     = head.msg_id;
  assign tx.opt_number = head.opt_number;
  assign tx.opt_length = head.opt_length;
  assign tx.opt_count  = head.opt_count;
  assign tx.is_final   = head.is_final;
  assign tx.status     = head.status;

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3)
    else $error("result queue overfilled");

  a_status_only_final: assert property (@(posedge clk) disable iff (rst)
    tx.valid && !tx.is_final |-> tx.status == ST_BUSY)
    else $error("status reported on a non-final byte");

  a_clear_after_final: assert property (@(posedge clk) disable iff (rst)
    accept && fin |=> pos == '0 && phase == PH_HEADER && err == ST_BUSY)
    else $error("message state not cleared after final byte");

  a_header_position: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HEADER && err == ST_BUSY |-> pos < POS_W'(4))
    else $error("header phase past fourth byte");

  a_opt_limit: assert property (@(posedge clk) disable iff (rst)
    opt_cnt <= CNT_W'(MAX_OPTIONS))
    else $error("option count above limit");

endmodule

`default_nettype wire

### tb/sv/coap_message_parser_tb.sv
// Self-checking testbench for coap_message_parser: drives datagram bytes on rx,
// predicts each classified result and checks it against tx, field by field.
// Depends on coap_pkg, coap_if and the coap_message_parser RTL.
`default_nettype none

module coap_message_parser_tb;
  import coap_pkg::*;

  localparam int MAX_BYTES    = 1024;
  localparam int MAX_OPTS     = 16;
  localparam int TOTAL_BYTES  = 1550;
  localparam int QUIET_LIMIT  = 1000;
  localparam status_t NO_FAULT = ST_BUSY;

  logic clk;
  logic rst;

  coap_in_if  rx_if ();
  coap_out_if tx_if ();

  coap_message_parser #(
    .MAX_DATAGRAM(MAX_BYTES),
    .MAX_OPTIONS (MAX_OPTS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .rx (rx_if),
    .tx (tx_if)
  );

  // Parser state as predicted from the accepted bytes
  phase_t      phase        = PH_HEADER;
  logic [10:0] byte_pos     = '0;
  logic [1:0]  h_type       = '0;
  logic [3:0]  h_tkl        = '0;
  logic [7:0]  h_code       = '0;
  logic [15:0] h_id         = '0;
  logic [15:0] opt_num      = '0;
  logic [16:0] ext_acc      = '0;
  logic [16:0] value_left   = '0;
  logic [7:0]  held_nibbles = '0;
  logic [4:0]  opts_seen    = '0;
  logic [15:0] cur_opt_len  = '0;
  status_t     fault        = NO_FAULT;

  result_t     classified_q[$];
  logic [7:0]  frame[$];
  int unsigned sent_bytes   = 0;
  int unsigned errors       = 0;
  bit          src_gaps_on  = 1'b1;
  bit          sink_gaps_on = 1'b1;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void take_length(int unsigned len);
    if (len > 65535) begin
      fault = ST_BADOPT;
      return;
    end
    cur_opt_len = 16'(len);
    value_left  = 17'(len);
    if (opts_seen != 5'd31) opts_seen++;
    phase = (len != 0) ? PH_VALUE : PH_OPTHEAD;
  endfunction

  function automatic void take_delta(int unsigned delta);
    int unsigned sum;
    sum = opt_num + delta;
    if (sum > 65535) begin
      fault = ST_BADOPT;
      return;
    end
    opt_num = 16'(sum);
    if (held_nibbles[3:0] == NIB_EXT8) phase = PH_L1;
    else if (held_nibbles[3:0] == NIB_EXT16) phase = PH_L2HI;
    else take_length(held_nibbles[3:0]);
  endfunction

  function automatic result_t classify_byte(logic [7:0] b, logic fin);
    result_t     r;
    kind_t       kind;
    status_t     st;
    int unsigned idx;
    kind = K_IGNORED;
    st   = ST_BUSY;
    if (byte_pos < MAX_BYTES) begin
      idx = byte_pos;
      byte_pos++;
      if (fault == NO_FAULT) begin
        case (phase)
          PH_HEADER: begin
            kind = K_HEADER;
            if (idx == 0) begin
              h_type = b[5:4];
              h_tkl  = b[3:0];
              if (b[7:6] != COAP_VER) fault = ST_VERSION;
              else if (b[3:0] > TKL_MAX) fault = ST_TOKEN;
            end else if (idx == 1) begin
              h_code = b;
            end else if (idx == 2) begin
              h_id = {b, 8'h00};
            end else begin
              h_id[7:0]  = b;
              value_left = 17'(h_tkl);
              phase = (h_tkl != 0) ? PH_TOKEN : PH_OPTHEAD;
            end
          end
          PH_TOKEN, PH_VALUE: begin
            kind = (phase == PH_TOKEN) ? K_TOKEN : K_VALUE;
            if (value_left != 0) value_left--;
            if (value_left == 0) phase = PH_OPTHEAD;
          end
          PH_OPTHEAD: begin
            if (b == PAYLOAD_MARK) begin
              kind  = K_MARKER;
              phase = PH_PAYLOAD;
            end else if (opts_seen >= MAX_OPTS) begin
              kind  = K_IGNORED;
              phase = PH_SKIP;
            end else begin
              kind = K_OPTHEAD;
              held_nibbles = b;
              if (b[7:4] == NIB_RSVD || b[3:0] == NIB_RSVD) fault = ST_BADOPT;
              else if (b[7:4] == NIB_EXT8) phase = PH_D1;
              else if (b[7:4] == NIB_EXT16) phase = PH_D2HI;
              else take_delta(b[7:4]);
            end
          end
          PH_D1: begin
            kind = K_OPTEXT;
            take_delta(b + EXT8_BIAS);
          end
          PH_D2HI, PH_L2HI: begin
            kind    = K_OPTEXT;
            ext_acc = {1'b0, b, 8'h00};
            phase   = (phase == PH_D2HI) ? PH_D2LO : PH_L2LO;
          end
          PH_D2LO: begin
            kind    = K_OPTEXT;
            ext_acc = (ext_acc | 17'(b)) + EXT16_BIAS;
            take_delta(ext_acc);
          end
          PH_L1: begin
            kind = K_OPTEXT;
            take_length(b + EXT8_BIAS);
          end
          PH_L2LO: begin
            kind    = K_OPTEXT;
            ext_acc = (ext_acc | 17'(b)) + EXT16_BIAS;
            take_length(ext_acc);
          end
          PH_PAYLOAD: kind = K_PAYLOAD;
          default:    kind = K_IGNORED;
        endcase
      end
    end

    if (fin) begin
      if (byte_pos < 4) st = ST_SHORT;
      else if (fault != NO_FAULT) st = fault;
      else if (phase >= PH_D1 && phase <= PH_VALUE) st = ST_TRUNC;
      else st = ST_OK;
    end

    r.byte_kind  = kind;
    r.data_byte  = b;
    r.msg_type   = h_type;
    r.token_len  = h_tkl;
    r.msg_code   = h_code;
    r.msg_id     = h_id;
    r.opt_number = opt_num;
    r.opt_length = cur_opt_len;
    r.opt_count  = opts_seen;
    r.is_final   = fin;
    r.status     = st;

    // Start the next datagram from a clean slate
    if (fin) begin
      phase        = PH_HEADER;
      byte_pos     = '0;
      h_type       = '0;
      h_tkl        = '0;
      h_code       = '0;
      h_id         = '0;
      opt_num      = '0;
      ext_acc      = '0;
      value_left   = '0;
      held_nibbles = '0;
      opts_seen    = '0;
      cur_opt_len  = '0;
      fault        = NO_FAULT;
    end
    return r;
  endfunction

  // Leave valid high after a transaction so back-to-back bytes need no toggle
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    result_t     r;
    gap = src_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_if.valid     <= 1'b1;
    rx_if.in_byte   <= b;
    rx_if.last_byte <= fin;
    do @(posedge clk); while (!rx_if.ready);
    r = classify_byte(b, fin);
    classified_q.push_back(r);
    sent_bytes++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame.size(); i++) send_byte(frame[i], i == frame.size() - 1);
  endtask

  task automatic match_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin : result_checker
    result_t     want;
    int unsigned stall;
    tx_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = sink_gaps_on ? $urandom_range(0, 6) : 0;
      if (stall != 0) begin
        tx_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      tx_if.ready <= 1'b1;
      do @(posedge clk); while (!tx_if.valid);
      if (classified_q.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual byte %h",
                 $time, tx_if.data_byte);
        errors++;
      end else begin
        want = classified_q.pop_front();
        match_field("byte_kind",  want.byte_kind,  tx_if.byte_kind);
        match_field("data_byte",  want.data_byte,  tx_if.data_byte);
        match_field("msg_type",   want.msg_type,   tx_if.msg_type);
        match_field("token_len",  want.token_len,  tx_if.token_len);
        match_field("msg_code",   want.msg_code,   tx_if.msg_code);
        match_field("msg_id",     want.msg_id,     tx_if.msg_id);
        match_field("opt_number", want.opt_number, tx_if.opt_number);
        match_field("opt_length", want.opt_length, tx_if.opt_length);
        match_field("opt_count",  want.opt_count,  tx_if.opt_count);
        match_field("is_final",   want.is_final,   tx_if.is_final);
        match_field("status",     want.status,     tx_if.status);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("coap_message_parser_tb failed");
    $finish;
  end

  task automatic test_header_fields();
    frame = {8'h40};
    send_frame();
    frame = {8'h40, 8'h01, 8'h02};
    send_frame();
    frame = {8'h00, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    frame = {8'hC8, 8'h01, 8'h00, 8'h00};
    send_frame();
    // Bad token length, then a byte that must be ignored
    frame = {8'h49, 8'h01, 8'h00, 8'h00, 8'hFF};
    send_frame();
    frame = {8'h78, 8'hFF, 8'hAB, 8'hCD, 8'h01, 8'h02, 8'h04, 8'h08,
             8'h10, 8'h20, 8'h40, 8'h80, 8'hFF, 8'h5A};
    send_frame();
    // Datagram ending inside the token is fine
    frame = {8'h62, 8'h45, 8'h12, 8'h34, 8'hAA};
    send_frame();
    frame = {8'h50, 8'h00, 8'h00, 8'h00};
    send_frame();
    frame = {8'h40, 8'h02, 8'h00, 8'h00, 8'hFF};
    send_frame();
  endtask

  task automatic test_option_encoding();
    frame = {8'h40, 8'h01, 8'h00, 8'h01, 8'hD1, 8'h00, 8'hAB, 8'h1E, 8'h00, 8'h00, 8'h11};
    send_frame();
    // Largest legal option number, then one past it
    frame = {8'h40, 8'h01, 8'h00, 8'h02, 8'hE0, 8'hFE, 8'hF2, 8'hFF, 8'h5A};
    send_frame();
    frame = {8'h40, 8'h01, 8'h00, 8'h03, 8'hE0, 8'hFE, 8'hF2, 8'h10, 8'h22};
    send_frame();
    frame = {8'h40, 8'h01, 8'h00, 8'h04, 8'h0D, 8'h00};
    repeat (13) frame.push_back(8'($urandom));
    send_frame();
    frame = {8'h40, 8'h01, 8'h00, 8'h05, 8'h0E, 8'hFE, 8'hF2, 8'h77};
    send_frame();
    frame = {8'h40, 8'h01, 8'h00, 8'h06, 8'h0E, 8'hFF, 8'hFF};
    send_frame();
    frame = {8'h40, 8'h01, 8'h00, 8'h07, 8'hE0, 8'hFF, 8'hFF};
    send_frame();
    frame = {8'h40, 8'h01, 8'h00, 8'h08, 8'hF0, 8'h00};
    send_frame();
    frame = {8'h40, 8'h01, 8'h00, 8'h09, 8'h3F};
    send_frame();
    frame = {8'h40, 8'h01, 8'h00, 8'h0A, 8'hD0};
    send_frame();
    frame = {8'h40, 8'h01, 8'h00, 8'h0B, 8'h0E, 8'h01};
    send_frame();
  endtask

  task automatic test_option_limit();
    frame = {8'h40, 8'h03, 8'h00, 8'h10};
    repeat (MAX_OPTS) frame.push_back(8'h00);
    frame = {frame, 8'h11, 8'hFF, 8'h42};
    send_frame();
    frame = {8'h40, 8'h03, 8'h00, 8'h11};
    repeat (MAX_OPTS) frame.push_back(8'h10);
    frame = {frame, 8'hFF, 8'hAA};
    send_frame();
  endtask

  // Option value still open when the size limit is hit
  task automatic test_oversize();
    frame = {8'h40, 8'h01, 8'hBE, 8'hEF, 8'h0E, 8'h03, 8'h00};
    repeat (1037) frame.push_back(8'($urandom));
    send_frame();
  endtask

  task automatic make_random_frame();
    logic [1:0]  ver;
    logic [3:0]  tkl;
    logic [3:0]  dn;
    logic [3:0]  ln;
    logic [15:0] ext;
    int unsigned n_opts;
    int unsigned sel;
    int unsigned len;
    int unsigned cut;
    frame = {};
    ver = ($urandom_range(0, 19) == 0) ? 2'($urandom) : COAP_VER;
    tkl = ($urandom_range(0, 19) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8));
    frame.push_back({ver, 2'($urandom), tkl});
    repeat (3) frame.push_back(8'($urandom));
    repeat (tkl) frame.push_back(8'($urandom));
    n_opts = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4);
    repeat (n_opts) begin
      sel = $urandom_range(0, 9);
      ext = 16'($urandom);
      dn  = (sel < 7) ? 4'($urandom_range(0, 12)) : (sel < 9) ? NIB_EXT8 : NIB_EXT16;
      sel = $urandom_range(0, 9);
      len = (sel < 7) ? $urandom_range(0, 4) :
            (sel < 9) ? $urandom_range(13, 20) : $urandom_range(269, 300);
      ln  = (len < 13) ? 4'(len) : (len < 269) ? NIB_EXT8 : NIB_EXT16;
      frame.push_back({dn, ln});
      if (dn == NIB_EXT8) begin
        frame.push_back(ext[7:0]);
      end else if (dn == NIB_EXT16) begin
        frame.push_back(ext[15:8]);
        frame.push_back(ext[7:0]);
      end
      if (ln == NIB_EXT8) begin
        frame.push_back(8'(len - 13));
      end else if (ln == NIB_EXT16) begin
        frame.push_back(8'((len - 269) >> 8));
        frame.push_back(8'(len - 269));
      end
      repeat (len) frame.push_back(8'($urandom));
    end
    if ($urandom_range(0, 1) == 1) begin
      frame.push_back(PAYLOAD_MARK);
      repeat ($urandom_range(0, 8)) frame.push_back(8'($urandom));
    end
    // Break some frames: cut short, corrupt one byte, or append noise
    case ($urandom_range(0, 9))
      0: begin
        cut = $urandom_range(1, frame.size());
        while (frame.size() > cut) void'(frame.pop_back());
      end
      1: frame[$urandom_range(0, frame.size() - 1)] = 8'($urandom);
      2: repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  // Top up the run with random datagrams until the byte budget is spent
  task automatic test_random_frames();
    while (sent_bytes < TOTAL_BYTES) begin
      src_gaps_on  = ($urandom_range(0, 3) != 0);
      sink_gaps_on = ($urandom_range(0, 3) != 0);
      make_random_frame();
      send_frame();
    end
  endtask

  initial begin
    rst             <= 1'b1;
    rx_if.valid     <= 1'b0;
    rx_if.in_byte   <= '0;
    rx_if.last_byte <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_header_fields();
    test_option_encoding();
    test_option_limit();
    test_oversize();
    test_random_frames();
    rx_if.valid <= 1'b0;
    while (classified_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("coap_message_parser_tb passed");
    end else begin
      $display("coap_message_parser_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
hw/rtl/coap_pkg.sv
hw/rtl/coap_if.sv
hw/rtl/coap_message_parser.sv
tb/sv/coap_message_parser_tb.sv
